// File: design/bsd_pkg.sv
// Shared types, codes and limits for the 24-bit BMP stream decoder.
`default_nettype none
package bsd_pkg;

	// Largest image the decoder takes; the counter widths follow from these.
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);

	// File header plus info header.
	localparam int FILE_HDR_BYTES = 14;
	localparam int INFO_HDR_BYTES = 40;
	localparam int HDR_BYTES      = FILE_HDR_BYTES + INFO_HDR_BYTES;

	localparam logic [15:0] BPP_RGB24    = 16'd24;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;

	// Result queue between the parser and the result ports.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Result kinds.
	localparam logic [2:0] KIND_PIXEL     = 3'd0;
	localparam logic [2:0] KIND_ACCEPT    = 3'd1;
	localparam logic [2:0] KIND_BAD_FMT   = 3'd2;
	localparam logic [2:0] KIND_BAD_SIZE  = 3'd3;
	localparam logic [2:0] KIND_TRUNCATED = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        final_pixel;
	} record_t;

endpackage
`default_nettype wire

// File: design/bsd_front.sv
// Front part: parses the header, tracks the pixel walk and builds result records.
`default_nettype none
module bsd_front (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             accept,
	input  bsd_pkg::item_t  item,
	output logic            wr_en,
	output bsd_pkg::record_t wr_data
);
	import bsd_pkg::*;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_PIXELS = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	localparam logic [5:0] HDR_LAST = 6'(HDR_BYTES - 1);
	localparam logic [5:0] OFF_LO = 6'd10;
	localparam logic [5:0] OFF_HI = 6'd13;
	localparam logic [5:0] WID_LO = 6'd18;
	localparam logic [5:0] WID_HI = 6'd21;
	localparam logic [5:0] HGT_LO = 6'd22;
	localparam logic [5:0] HGT_HI = 6'd25;
	localparam logic [5:0] BPP_LO = 6'd28;
	localparam logic [5:0] BPP_HI = 6'd29;

	logic [1:0]       phase_q;
	logic [5:0]       hdr_cnt_q;
	logic [31:0]      offset_q;
	logic [31:0]      width_q;
	logic [31:0]      height_q;
	logic [15:0]      bpp_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] rows_q;
	logic [1:0]       bip_q;
	logic [1:0]       pad_q;
	logic [7:0]       blue_q;
	logic [7:0]       green_q;

	logic             eos;
	logic [7:0]       b;
	logic             is_hdr;
	logic             is_pix;
	logic             hdr_last;
	logic [1:0]       lane;
	logic [2:0]       verdict;
	logic [COL_W-1:0] width_c;
	logic [ROW_W-1:0] height_c;
	logic             in_pad;
	logic [1:0]       pad_dec;
	logic [COL_W-1:0] col_inc;
	logic [ROW_W-1:0] rows_inc;
	logic             emit_pix;
	logic [31:0]      col_ext;
	logic [31:0]      y_ext;

	assign eos      = item.end_of_stream;
	assign b        = item.data_byte;
	assign is_hdr   = (phase_q == PH_HEADER);
	assign is_pix   = (phase_q == PH_PIXELS);
	assign hdr_last = (hdr_cnt_q == HDR_LAST);
	// Each 32-bit field starts at a byte index that is 2 modulo 4.
	assign lane     = hdr_cnt_q[1:0] - 2'd2;

	// Width and height only reach the pixel phase once they fit the limits.
	assign width_c  = width_q[COL_W-1:0];
	assign height_c = height_q[ROW_W-1:0];
	assign in_pad   = (col_q >= width_c);
	assign pad_dec  = (pad_q != 2'd0) ? pad_q - 2'd1 : 2'd0;
	assign col_inc  = col_q + COL_W'(1);
	assign rows_inc = rows_q + ROW_W'(1);
	assign col_ext  = 32'(col_q);
	assign y_ext    = height_q - 32'd1 - 32'(rows_q);

	always_comb begin
		if (offset_q != 32'(HDR_BYTES) || bpp_q != BPP_RGB24 || height_q[31] ||
		    height_q == 32'd0) begin
			verdict = KIND_BAD_FMT;
		end else if (width_q[31] || width_q == 32'd0 || width_q > 32'(MAX_WIDTH) ||
		             height_q > 32'(MAX_HEIGHT)) begin
			verdict = KIND_BAD_SIZE;
		end else begin
			verdict = KIND_ACCEPT;
		end
	end

	assign emit_pix = is_pix && !eos && !in_pad && (bip_q != 2'd0) && (bip_q != 2'd1);

	always_comb begin
		wr_en   = accept && (is_hdr || is_pix) && (eos || (is_hdr && hdr_last) || emit_pix);
		wr_data = '0;
		if (eos) begin
			wr_data.kind = KIND_TRUNCATED;
		end else if (is_hdr) begin
			wr_data.kind = verdict;
		end else begin
			wr_data.kind        = KIND_PIXEL;
			wr_data.pixel_x     = col_ext[11:0];
			wr_data.pixel_y     = y_ext[11:0];
			wr_data.red         = b;
			wr_data.green       = green_q;
			wr_data.blue        = blue_q;
			wr_data.alpha       = ALPHA_OPAQUE;
			wr_data.final_pixel = (col_inc == width_c) && (rows_inc == height_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= '0;
			offset_q  <= '0;
			width_q   <= '0;
			height_q  <= '0;
			bpp_q     <= '0;
			col_q     <= '0;
			rows_q    <= '0;
			bip_q     <= '0;
			pad_q     <= '0;
			blue_q    <= '0;
			green_q   <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (eos) begin
						phase_q <= PH_DONE;
					end else begin
						if (hdr_cnt_q >= OFF_LO && hdr_cnt_q <= OFF_HI) begin
							offset_q[8*lane +: 8] <= b;
						end else if (hdr_cnt_q >= WID_LO && hdr_cnt_q <= WID_HI) begin
							width_q[8*lane +: 8] <= b;
						end else if (hdr_cnt_q >= HGT_LO && hdr_cnt_q <= HGT_HI) begin
							height_q[8*lane +: 8] <= b;
						end else if (hdr_cnt_q >= BPP_LO && hdr_cnt_q <= BPP_HI) begin
							bpp_q[8*hdr_cnt_q[0] +: 8] <= b;
						end
						hdr_cnt_q <= hdr_cnt_q + 6'd1;
						if (hdr_last) begin
							if (verdict == KIND_ACCEPT) begin
								phase_q <= PH_PIXELS;
								col_q   <= '0;
								rows_q  <= '0;
								bip_q   <= '0;
								pad_q   <= '0;
							end else begin
								phase_q <= PH_DONE;
							end
						end
					end
				end
				PH_PIXELS: begin
					if (eos) begin
						phase_q <= PH_DONE;
					end else if (in_pad) begin
						pad_q <= pad_dec;
						if (pad_dec == 2'd0) begin
							col_q  <= '0;
							rows_q <= rows_inc;
							if (rows_inc >= height_c) begin
								phase_q <= PH_DONE;
							end
						end
					end else if (bip_q == 2'd0) begin
						blue_q <= b;
						bip_q  <= 2'd1;
					end else if (bip_q == 2'd1) begin
						green_q <= b;
						bip_q   <= 2'd2;
					end else begin
						bip_q <= 2'd0;
						col_q <= col_inc;
						// The pad count is the width modulo four, as the file format walk here defines it.
						if (col_inc >= width_c) begin
							pad_q <= width_c[1:0];
							if (width_c[1:0] == 2'd0) begin
								col_q  <= '0;
								rows_q <= rows_inc;
								if (rows_inc >= height_c) begin
									phase_q <= PH_DONE;
								end
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: design/bsd_queue.sv
// Back part: a short result queue whose head drives the result ports.
`default_nettype none
module bsd_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              wr_en,
	input  bsd_pkg::record_t wr_data,
	input  wire              rd_en,
	output logic             full,
	output logic             empty,
	output bsd_pkg::record_t rd_data
);
	import bsd_pkg::*;

	record_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_rd;

	assign full    = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (wr_en && !do_rd) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (do_rd && !wr_en) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: design/bmp24_stream_decoder.sv
// Top level of the 24-bit uncompressed BMP stream decoder.
//
//   channel   direction  handshake           payload
//   item      in         push / full         bsd_pkg::item_t   (byte, end of stream)
//   result    out        empty / pop         bsd_pkg::record_t (kind, pixel, flags)
//
// One byte is taken every cycle while full is low; the parser updates its
// counters and header fields in that same cycle and writes at most one record.
// Results wait in a four-entry queue, so the input stalls only when the
// consumer leaves four results untaken. Reset clears the parser to the header
// phase and empties the queue. After a verdict reject, a truncation or the
// last row's padding, further bytes are still taken and give no result.
`default_nettype none
module bmp24_stream_decoder (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	output logic             full,
	input  bsd_pkg::item_t   item,
	output logic             empty,
	input  wire              pop,
	output bsd_pkg::record_t result
);
	import bsd_pkg::*;

	logic    accept;
	logic    wr_en;
	record_t wr_data;

	// A transfer happens only when the queue has room for the result it may cause.
	assign accept = push && !full;

	bsd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	bsd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.rd_en   (pop),
		.full    (full),
		.empty   (empty),
		.rd_data (result)
	);

endmodule
`default_nettype wire

// File: sim/bmp24_stream_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the BMP stream decoder: one image per run, scored against a model.
module bmp24_stream_decoder_tb;
	import bsd_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 16;
	localparam int CHUNK_ITEMS  = 150;
	localparam int TAIL_ITEMS   = 24;
	localparam int PIXEL_BYTES  = 1800;

	typedef enum logic [1:0] {PH_HEADER, PH_PIXELS, PH_DONE} parse_phase_e;
	typedef enum int {END_COMPLETE, END_CUT_PADDING, END_CUT_PIXELS} stream_end_e;

	typedef struct {
		item_t   it;
		logic    typed;
		record_t want;
	} stim_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    pop = 1'b0;
	item_t   item = '0;
	logic    full;
	logic    empty;
	record_t result;

	// Hand-written verdict that travels with the item it belongs to.
	logic    typed_on = 1'b0;
	record_t typed_rec = '0;

	int send_idle = 0;
	int recv_stall = 0;
	int sent_items = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	// Decoder state as the predictor sees it.
	parse_phase_e     ph = PH_HEADER;
	logic [5:0]       hdr_cnt = '0;
	logic [31:0]      ofs_field = '0;
	logic [31:0]      width_field = '0;
	logic [31:0]      height_field = '0;
	logic [15:0]      bpp_field = '0;
	logic [COL_W-1:0] col_cnt = '0;
	logic [ROW_W-1:0] rows_cnt = '0;
	logic [1:0]       byte_idx = '0;
	logic [1:0]       pad_cnt = '0;
	logic [7:0]       blue_hold = '0;
	logic [7:0]       green_hold = '0;

	record_t decoded_records[$];

	always #5 clk = ~clk;

	bmp24_stream_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	function automatic record_t kind_only(input logic [2:0] k);
		record_t r;
		r = '0;
		r.kind = k;
		return r;
	endfunction

	task automatic close_row();
		col_cnt = '0;
		rows_cnt = rows_cnt + 1'b1;
		if (rows_cnt >= height_field) begin
			ph = PH_DONE;
		end
	endtask

	task automatic decode_byte(input item_t it, output logic got, output record_t rec);
		int unsigned i;
		got = 1'b0;
		rec = '0;
		if (ph == PH_DONE) begin
			return;
		end
		if (it.end_of_stream) begin
			got = 1'b1;
			rec = kind_only(KIND_TRUNCATED);
			ph = PH_DONE;
			return;
		end
		if (ph == PH_HEADER) begin
			i = hdr_cnt;
			if (i >= 10 && i <= 13) begin
				ofs_field |= 32'(it.data_byte) << (8 * (i - 10));
			end else if (i >= 18 && i <= 21) begin
				width_field |= 32'(it.data_byte) << (8 * (i - 18));
			end else if (i >= 22 && i <= 25) begin
				height_field |= 32'(it.data_byte) << (8 * (i - 22));
			end else if (i >= 28 && i <= 29) begin
				bpp_field |= 16'(it.data_byte) << (8 * (i - 28));
			end
			hdr_cnt = hdr_cnt + 1'b1;
			if (hdr_cnt < HDR_BYTES) begin
				return;
			end
			got = 1'b1;
			if (ofs_field != HDR_BYTES || bpp_field != BPP_RGB24 || $signed(height_field) <= 0) begin
				rec = kind_only(KIND_BAD_FMT);
				ph = PH_DONE;
			end else if ($signed(width_field) <= 0 || width_field > MAX_WIDTH ||
					height_field > MAX_HEIGHT) begin
				rec = kind_only(KIND_BAD_SIZE);
				ph = PH_DONE;
			end else begin
				rec = kind_only(KIND_ACCEPT);
				ph = PH_PIXELS;
				col_cnt = '0;
				rows_cnt = '0;
				byte_idx = '0;
				pad_cnt = '0;
			end
			return;
		end
		// Past the last column only padding remains in the row.
		if (col_cnt >= width_field) begin
			if (pad_cnt > 0) begin
				pad_cnt = pad_cnt - 1'b1;
			end
			if (pad_cnt == 0) begin
				close_row();
			end
			return;
		end
		if (byte_idx == 0) begin
			blue_hold = it.data_byte;
			byte_idx = 1;
			return;
		end
		if (byte_idx == 1) begin
			green_hold = it.data_byte;
			byte_idx = 2;
			return;
		end
		byte_idx = 0;
		got = 1'b1;
		rec.kind = KIND_PIXEL;
		rec.pixel_x = col_cnt[11:0];
		rec.pixel_y = 12'(height_field - 1 - rows_cnt);
		rec.red = it.data_byte;
		rec.green = green_hold;
		rec.blue = blue_hold;
		rec.alpha = ALPHA_OPAQUE;
		rec.final_pixel = (col_cnt + 1 == width_field) && (rows_cnt + 1 == height_field);
		col_cnt = col_cnt + 1'b1;
		if (col_cnt >= width_field) begin
			pad_cnt = width_field[1:0];
			if (pad_cnt == 0) begin
				close_row();
			end
		end
	endtask

	function automatic void match_field(input string name, input int unsigned want,
			input int unsigned seen);
		if (want != seen) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	// Scoreboard: results are checked before the item taken at the same edge is predicted.
	always @(posedge clk) begin
		logic    got;
		record_t rec;
		record_t want;
		if (arst_n) begin
			if ((pop && !empty) || (push && !full)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (pop && !empty) begin
				if (decoded_records.size() == 0) begin
					$display("%0t: result expected none actual %p", $time, result);
					mismatches++;
				end else begin
					want = decoded_records.pop_front();
					match_field("kind", want.kind, result.kind);
					match_field("pixel_x", want.pixel_x, result.pixel_x);
					match_field("pixel_y", want.pixel_y, result.pixel_y);
					match_field("red", want.red, result.red);
					match_field("green", want.green, result.green);
					match_field("blue", want.blue, result.blue);
					match_field("alpha", want.alpha, result.alpha);
					match_field("final_pixel", want.final_pixel, result.final_pixel);
				end
			end
			if (push && !full) begin
				decode_byte(item, got, rec);
				if (typed_on) begin
					got = 1'b1;
					rec = typed_rec;
				end
				if (got) begin
					decoded_records.push_back(rec);
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic push_item(input item_t it, input logic typed, input record_t want);
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		typed_on <= typed;
		typed_rec <= want;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		sent_items++;
		// Rotate through no idling, sender gaps, receiver stalls and light gaps on both.
		case ((sent_items / CHUNK_ITEMS) % 4)
			0: begin
				send_idle = 0;
				recv_stall <= 0;
			end
			1: begin
				send_idle = 86;
				recv_stall <= 0;
			end
			2: begin
				send_idle = 0;
				recv_stall <= 86;
			end
			default: begin
				send_idle = 13;
				recv_stall <= 13;
			end
		endcase
	endtask

	initial begin
		logic [7:0]  hdr [HDR_BYTES];
		stim_row_t   script[$];
		stim_row_t   row;
		item_t       it;
		int unsigned img_w;
		int unsigned img_h;
		int unsigned pad;
		int unsigned pix_bytes;
		int unsigned cut_at;
		int unsigned pick;
		stream_end_e ending;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Mostly small images; now and then a full-width row or a full-height column.
		pick = $urandom_range(0, 7);
		if (pick == 0) begin
			img_w = MAX_WIDTH;
			img_h = 1;
		end else if (pick == 1) begin
			img_w = 1;
			img_h = MAX_HEIGHT;
		end else begin
			img_w = $urandom_range(1, 48);
			img_h = 1800 / (3 * img_w + (img_w & 3));
		end
		pad = img_w & 3;
		pix_bytes = img_h * (3 * img_w + pad);

		ending = stream_end_e'($urandom_range(0, 2));
		if (ending == END_CUT_PADDING && pad == 0) begin
			ending = END_COMPLETE;
		end
		// A full-width row or a full-height column is far longer than one run, so it is cut short.
		if (pix_bytes > PIXEL_BYTES) begin
			ending = END_CUT_PIXELS;
		end
		case (ending)
			END_CUT_PADDING: cut_at = pix_bytes - pad + $urandom_range(0, pad - 1);
			END_CUT_PIXELS: begin
				if (pix_bytes > PIXEL_BYTES) begin
					cut_at = $urandom_range(PIXEL_BYTES - 64, PIXEL_BYTES);
				end else begin
					cut_at = $urandom_range(pix_bytes - pix_bytes / 4, pix_bytes - 1);
				end
			end
			default:         cut_at = pix_bytes;
		endcase

		for (int n = 0; n < HDR_BYTES; n++) begin
			hdr[n] = 8'($urandom_range(0, 255));
		end
		hdr[0] = "B";
		hdr[1] = "M";
		for (int n = 0; n < 4; n++) begin
			hdr[2 + n]  = 8'((HDR_BYTES + pix_bytes) >> (8 * n));
			hdr[10 + n] = 8'(HDR_BYTES >> (8 * n));
			hdr[14 + n] = 8'(INFO_HDR_BYTES >> (8 * n));
			hdr[18 + n] = 8'(img_w >> (8 * n));
			hdr[22 + n] = 8'(img_h >> (8 * n));
		end
		hdr[26] = 8'd1;
		hdr[27] = 8'd0;
		hdr[28] = BPP_RGB24[7:0];
		hdr[29] = BPP_RGB24[15:8];

		// The verdict on the last header byte is known without the predictor.
		for (int n = 0; n < HDR_BYTES; n++) begin
			row.it = '{data_byte: hdr[n], end_of_stream: 1'b0};
			row.typed = (n == HDR_BYTES - 1);
			row.want = row.typed ? kind_only(KIND_ACCEPT) : '0;
			script.push_back(row);
		end
		// First pixel at the extremes of the color bytes.
		row.typed = 1'b0;
		row.want = '0;
		row.it = '{data_byte: 8'hff, end_of_stream: 1'b0};
		script.push_back(row);
		row.it = '{data_byte: 8'h00, end_of_stream: 1'b0};
		script.push_back(row);
		row.it = '{data_byte: 8'hff, end_of_stream: 1'b0};
		script.push_back(row);

		foreach (script[r]) begin
			push_item(script[r].it, script[r].typed, script[r].want);
		end

		for (int unsigned n = 3; n < pix_bytes; n++) begin
			if (n == cut_at) begin
				push_item('{data_byte: 8'($urandom_range(0, 255)), end_of_stream: 1'b1}, 1'b0, '0);
				break;
			end
			pick = $urandom_range(0, 9);
			it.end_of_stream = 1'b0;
			it.data_byte = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom_range(0, 255));
			push_item(it, 1'b0, '0);
		end

		// Once the stream is over, bytes and end markers alike must produce nothing.
		for (int n = 0; n < TAIL_ITEMS; n++) begin
			it.data_byte = 8'($urandom_range(0, 255));
			it.end_of_stream = (n == 0) ? 1'b1 : 1'($urandom_range(0, 1));
			push_item(it, 1'b0, '0);
		end
		push <= 1'b0;

		while (decoded_records.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && decoded_records.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
